// ----- rtl/core/presence_change_filter_cache_defines.svh -----
// Assertion macros for the presence change filter cache.
`ifndef PRESENCE_CHANGE_FILTER_CACHE_DEFINES_SVH
`define PRESENCE_CHANGE_FILTER_CACHE_DEFINES_SVH

`ifndef SYNTH
// Checked only outside reset.
`define PCFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define PCFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PCFC_ASSERT(lbl, prop, msg)
`define PCFC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/pcfc_pkg.sv -----
package pcfc_pkg;

  localparam int CACHE_ENTRIES = 8;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  localparam int ADDR_W = 16;
  localparam int ST_W = 2;
  localparam int VERD_W = 2;
  localparam int ENTRY_W = ADDR_W + ST_W;

  localparam logic [ADDR_W-1:0] UNICAST_MAX = 16'h7FFF;

  // APB: one 32-bit register at byte 0; paddr[2] is the word index.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_LOCAL_ADDR = 1'b0;

  typedef enum logic [VERD_W-1:0] {
    V_NONE    = 2'd0,
    V_SELF    = 2'd1,
    V_DIRECT  = 2'd2,
    V_CHANGED = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DECIDE,
    S_DONE
  } state_t;

endpackage

// ----- rtl/core/pcfc_report_if.sv -----
interface pcfc_report_if;
  import pcfc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] src_addr;
  logic [ADDR_W-1:0] dst_addr;
  logic [ST_W-1:0]   status;

  modport source(output valid, output src_addr, output dst_addr, output status, input ready);
  modport sink(input valid, input src_addr, input dst_addr, input status, output ready);
endinterface

// ----- rtl/core/pcfc_verdict_if.sv -----
interface pcfc_verdict_if;
  import pcfc_pkg::*;

  logic              valid;
  logic              ready;
  logic [VERD_W-1:0] verdict;
  logic [ST_W-1:0]   echo_status;

  modport source(output valid, output verdict, output echo_status, input ready);
  modport sink(input valid, input verdict, input echo_status, output ready);
endinterface

// ----- rtl/core/pcfc_ram.sv -----
module pcfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                               rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/presence_change_filter_cache.sv -----
// Presence change filter with a small fully associative cache.
// Input channel (report): one beat carries src_addr, dst_addr and status.
// Output channel (result): one beat per report, verdict and echo_status.
// Config: APB write of local_addr at byte 0 (pready tied high), readable.
// Reports from the local address, or with a unicast destination, are
// classified at once: the accept moves the block straight to S_DONE, which
// loads the output register as soon as it is free and then returns to idle.
// Other reports walk the cache RAM, one read per cycle on its single read
// port: a read of every entry (S_SCAN), the compare of the last read
// (S_LAST), a decide/write-back step (S_DECIDE) and the load of the output
// register in S_DONE, which also waits while that register is still full.
// One report is in flight at a time; ready is high only while idle.
// The result sits in an output register; a stalled receiver keeps it there,
// and the next report is still accepted and worked on, holding only its own
// result until the register frees.
// Reset (rst, synchronous): local_addr = 0, replace head = 0, per-entry
// valid flops cleared so every slot reads as empty (address 0, status 0).
// No clearing pass is needed; the block is ready on the cycle after reset.
`include "presence_change_filter_cache_defines.svh"

module presence_change_filter_cache (
  input  logic                         clk,
  input  logic                         rst,
  pcfc_report_if.sink                  report,
  pcfc_verdict_if.source               result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pcfc_pkg::PADDR_W-1:0] paddr,
  input  logic [pcfc_pkg::PDATA_W-1:0] pwdata,
  output logic [pcfc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import pcfc_pkg::*;

  state_t state, state_next;

  // Config register
  logic [ADDR_W-1:0] local_addr;
  logic              cfg_wr;

  // Latched report and its result
  logic [ADDR_W-1:0] item_src;
  logic [ST_W-1:0]   item_st;
  verdict_t          verd;

  // Read walk and compare stage
  logic [CNT_W-1:0]  rd_cnt;
  logic [IDX_W-1:0]  rd_idx;
  logic              cmp_valid;
  logic [IDX_W-1:0]  cmp_idx;
  logic [ENTRY_W-1:0] rd_data;
  logic [ADDR_W-1:0] eff_addr;
  logic [ST_W-1:0]   eff_st;

  // Scan results
  logic              hit_found;
  logic [IDX_W-1:0]  hit_idx;
  logic [ST_W-1:0]   hit_st;
  logic              empty_found;
  logic [IDX_W-1:0]  empty_idx;

  // Entry valid flops: an entry never written reads as empty
  logic [CACHE_ENTRIES-1:0] valid;
  logic [IDX_W-1:0]  head;

  // Write-back
  logic              hit_same;
  logic              wr_en;
  logic              evict;
  logic [IDX_W-1:0]  wr_idx;

  logic              in_fire;
  logic              out_free;
  logic              fast_path;
  logic              dst_unicast;
  logic              is_local;
  logic              ovalid;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LOCAL_ADDR);
  assign prdata = (paddr[2] == REG_LOCAL_ADDR) ?
                  {{(PDATA_W-ADDR_W){1'b0}}, local_addr} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_addr <= '0;
    end else if (cfg_wr) begin
      local_addr <= pwdata[ADDR_W-1:0];
    end
  end

  // ---------------- classification of the incoming beat ----------------
  assign dst_unicast = (report.dst_addr != '0) && (report.dst_addr <= UNICAST_MAX);
  assign is_local    = (report.src_addr == local_addr);
  assign fast_path   = is_local || dst_unicast;
  assign in_fire     = report.valid && report.ready;
  assign out_free    = !ovalid || result.ready;

  // ---------------- cache RAM ----------------
  assign rd_idx = rd_cnt[IDX_W-1:0];

  pcfc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CACHE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_idx),
    .wdata({item_src, item_st}),
    .raddr(rd_idx),
    .rdata(rd_data)
  );

  // An entry without its valid bit reads as address 0, status 0.
  assign eff_addr = valid[cmp_idx] ? rd_data[ENTRY_W-1:ST_W] : '0;
  assign eff_st   = valid[cmp_idx] ? rd_data[ST_W-1:0] : '0;

  // Lowest matching slot wins; else lowest empty slot; else the FIFO head.
  assign hit_same = hit_found && (hit_st == item_st);
  assign wr_idx   = hit_found ? hit_idx : (empty_found ? empty_idx : head);

  // ---------------- state machine ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (report.valid) begin
          state_next = fast_path ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_cnt == CNT_W'(CACHE_ENTRIES - 1)) begin
          state_next = S_LAST;
        end
      end
      S_LAST:   state_next = S_DECIDE;
      S_DECIDE: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    report.ready = (state == S_IDLE);
    wr_en        = (state == S_DECIDE) && !hit_same;
    evict        = (state == S_DECIDE) && !hit_found && !empty_found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid   <= 1'b0;
      valid       <= '0;
      head        <= '0;
      rd_cnt      <= '0;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
    end else begin
      cmp_valid <= (state == S_SCAN);
      cmp_idx   <= rd_idx;

      if (in_fire) begin
        rd_cnt      <= '0;
        hit_found   <= 1'b0;
        empty_found <= 1'b0;
      end else if (state == S_SCAN) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
      end

      if (cmp_valid) begin
        if (!hit_found && (eff_addr == item_src)) begin
          hit_found <= 1'b1;
          hit_idx   <= cmp_idx;
          hit_st    <= eff_st;
        end
        if (!empty_found && (eff_addr == '0)) begin
          empty_found <= 1'b1;
          empty_idx   <= cmp_idx;
        end
      end

      if (wr_en) begin
        valid[wr_idx] <= 1'b1;
      end
      if (evict) begin
        head <= (head == IDX_W'(CACHE_ENTRIES - 1)) ? '0 : head + IDX_W'(1);
      end
    end
  end

  // Report latch and verdict.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_src <= report.src_addr;
      item_st  <= report.status;
      if (is_local) begin
        verd <= dst_unicast ? V_SELF : V_NONE;
      end else begin
        verd <= V_DIRECT;
      end
    end else if (state == S_DECIDE) begin
      verd <= hit_same ? V_NONE : V_CHANGED;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      ovalid <= 1'b1;
    end else if (result.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      result.verdict     <= verd;
      result.echo_status <= item_st;
    end
  end

  assign result.valid = ovalid;

  // ---------------- assertions ----------------
  `PCFC_ASSERT(a_walk_bound, rd_cnt <= CNT_W'(CACHE_ENTRIES), "read walk ran past the cache")
  `PCFC_ASSERT(a_head_on_evict, !$stable(head) |-> $past(evict), "replace head moved without an eviction")
  `PCFC_ASSERT(a_valid_grows, !$past(rst) |-> ((valid & $past(valid)) == $past(valid)), "entry valid bit dropped outside reset")
  `PCFC_ASSERT_ALWAYS(a_reset_clears, $past(rst) |-> (valid == '0 && head == '0 && !ovalid), "reset left cache state behind")

endmodule

// ----- tb/sv/pcfc_verdict_checker.sv -----
module pcfc_verdict_checker (
  input  logic                         clk,
  input  logic                         rst,
  pcfc_report_if                       report,
  pcfc_verdict_if                      result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [pcfc_pkg::PADDR_W-1:0] paddr,
  input  logic [pcfc_pkg::PDATA_W-1:0] pwdata,
  input  logic [pcfc_pkg::PDATA_W-1:0] prdata,
  output int                           mismatches,
  output int                           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import pcfc_pkg::*;

  typedef struct packed {
    verdict_t        verdict;
    logic [ST_W-1:0] echo_status;
  } outcome_t;

  // Shadow of the block's cache and register.
  logic [ADDR_W-1:0] node_addr;
  logic [ADDR_W-1:0] seen_addr   [CACHE_ENTRIES];
  logic [ST_W-1:0]   seen_status [CACHE_ENTRIES];
  int                evict_ptr;

  outcome_t pending_q[$];

  function automatic logic is_unicast(input logic [ADDR_W-1:0] a);
    return (a != '0) && (a <= UNICAST_MAX);
  endfunction

  // Classify one report and update the shadow cache.
  function automatic verdict_t classify_report(input logic [ADDR_W-1:0] src,
                                               input logic [ADDR_W-1:0] dst,
                                               input logic [ST_W-1:0]   st);
    int slot;
    slot = CACHE_ENTRIES;
    if (src == node_addr) begin
      return is_unicast(dst) ? V_SELF : V_NONE;
    end
    if (is_unicast(dst)) begin
      return V_DIRECT;
    end
    // lowest matching slot; address 0 matches the lowest empty slot
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (slot == CACHE_ENTRIES && seen_addr[i] == src) slot = i;
    end
    if (slot != CACHE_ENTRIES && seen_status[slot] == st) begin
      return V_NONE;
    end
    if (slot == CACHE_ENTRIES) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        if (slot == CACHE_ENTRIES && seen_addr[i] == '0) slot = i;
      end
    end
    if (slot == CACHE_ENTRIES) begin
      slot = evict_ptr;
      evict_ptr = (evict_ptr + 1 >= CACHE_ENTRIES) ? 0 : evict_ptr + 1;
    end
    seen_addr[slot] = src;
    seen_status[slot] = st;
    return V_CHANGED;
  endfunction

  task automatic flag_mismatch(input string what, input int want, input int got);
    if (mismatches < 10) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      mismatches = 0;
      node_addr = '0;
      evict_ptr = 0;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        seen_addr[i] = '0;
        seen_status[i] = '0;
      end
      pending_q.delete();
    end else begin
      // results always trail their report through the output register, so pop first
      if (result.valid && result.ready) begin
        if (pending_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected result beat, verdict 0x%0h status 0x%0h",
                     $realtime, result.verdict, result.echo_status);
          end
          mismatches++;
        end else begin
          want = pending_q.pop_front();
          if (result.verdict !== want.verdict) begin
            flag_mismatch("verdict", int'(want.verdict), int'(result.verdict));
          end
          if (result.echo_status !== want.echo_status) begin
            flag_mismatch("echo_status", int'(want.echo_status), int'(result.echo_status));
          end
        end
      end
      if (report.valid && report.ready) begin
        want.verdict = classify_report(report.src_addr, report.dst_addr, report.status);
        want.echo_status = report.status;
        pending_q.push_back(want);
      end
      if (psel && penable && pready && paddr[2] == REG_LOCAL_ADDR) begin
        if (pwrite) begin
          node_addr = pwdata[ADDR_W-1:0];
        end else if (prdata !== PDATA_W'(node_addr)) begin
          flag_mismatch("local_addr readback", int'(node_addr), int'(prdata));
        end
      end
    end
    outstanding <= pending_q.size();
  end

endmodule

// ----- tb/sv/tb_presence_change_filter_cache.sv -----
module tb_presence_change_filter_cache;
  timeunit 1ns;
  timeprecision 1ps;
  import pcfc_pkg::*;

  // Register offsets: paddr[2] selects the word, only word 0 exists.
  localparam logic [PADDR_W-1:0] LOCAL_ADDR_OFFSET = {REG_LOCAL_ADDR, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_OFFSET      = {~REG_LOCAL_ADDR, 2'b00};

  localparam int PHASES      = 6;
  localparam int PHASE_BEATS = 135;
  localparam int POOL_MAX    = 12;

  logic clk;
  logic rst;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  pcfc_report_if  report_ch();
  pcfc_verdict_if result_ch();

  int mismatches;
  int outstanding;

  // Idling knobs, flipped per phase so some stretches run with no gaps.
  logic tx_gaps;
  logic rx_stalls;
  int   rx_hold;

  // Stimulus-side view of the configured node address and a per-phase set of
  // sender addresses; reusing a small set is what drives cache hits, and a
  // set bigger than the cache forces round-robin eviction.
  logic [ADDR_W-1:0] node_addr_cur;
  logic [ADDR_W-1:0] addr_pool [POOL_MAX];
  int                pool_len;

  presence_change_filter_cache dut (
    .clk     (clk),
    .rst     (rst),
    .report  (report_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pcfc_verdict_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .report      (report_ch),
    .result      (result_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result-side backpressure: ready alternates between high runs and low
  // stalls. About one stall in ten is long.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (!rx_stalls || !result_ch.ready) begin
      result_ch.ready <= 1'b1;
      rx_hold <= $urandom_range(0, 15);
    end else begin
      result_ch.ready <= 1'b0;
      rx_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end
  end

  // Hard stop; the slowest legal run is far shorter than this.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!tx_gaps || roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one report beat and hold it until the block takes it. Valid is
  // left high after the accepting edge; a back-to-back beat just swaps the
  // payload, and only a gap or drain_verdicts lowers valid.
  task automatic send_report(input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] dst,
                             input logic [ST_W-1:0] st);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      report_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    report_ch.valid    <= 1'b1;
    report_ch.src_addr <= src;
    report_ch.dst_addr <= dst;
    report_ch.status   <= st;
    do @(posedge clk); while (!report_ch.ready);
  endtask

  // Stop sending and wait for every outstanding verdict. The first edge lets
  // the checker count the beat accepted on the edge we were called at. Each
  // report always yields a verdict, so once the count is zero the block is idle.
  task automatic drain_verdicts();
    report_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Readback data is compared by the checker during the access phase.
  task automatic apb_read(input logic [PADDR_W-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper data bits carry noise; only the low 16 bits land in the register.
  task automatic set_node_addr(input logic [ADDR_W-1:0] addr);
    apb_write(LOCAL_ADDR_OFFSET, {16'($urandom), addr});
    node_addr_cur = addr;
    apb_read(LOCAL_ADDR_OFFSET);
  endtask

  // Random report, weighted toward the cache path: mostly pooled senders on
  // broadcast/group destinations, some self and direct traffic, some noise.
  task automatic send_random_report();
    int                roll;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    roll = $urandom_range(0, 99);
    if (roll < 62)      src = addr_pool[$urandom_range(0, pool_len - 1)];
    else if (roll < 72) src = node_addr_cur;
    else if (roll < 77) src = '0;
    else                src = ADDR_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 10)      dst = '0;
    else if (roll < 65) dst = ADDR_W'($urandom_range(16'h8000, 16'hFFFF));
    else if (roll < 90) dst = ADDR_W'($urandom_range(1, 16'h7FFF));
    else                dst = ADDR_W'($urandom);
    send_report(src, dst, ST_W'($urandom_range(0, 3)));
  endtask

  initial begin
    rst = 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    report_ch.valid <= 1'b0;
    report_ch.src_addr <= '0;
    report_ch.dst_addr <= '0;
    report_ch.status <= '0;
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    node_addr_cur = '0;
    pool_len = 1;
    addr_pool[0] = 16'h0001;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // Node address is still zero after reset, so sender 0 counts as local.
    send_report(16'h0000, 16'h0000, 2'd0);   // local, destination 0: none
    send_report(16'h0000, 16'h0001, 2'd3);   // local, lowest unicast: self
    send_report(16'h0000, 16'hFFFF, 2'd1);   // local, group: none
    drain_verdicts();

    // Configure, then poke the unmapped word: that write must be dropped.
    set_node_addr(16'h1234);
    apb_write(SPARE_OFFSET, 32'hFFFF_BEEF);
    apb_read(LOCAL_ADDR_OFFSET);

    send_report(16'h1234, 16'h7FFF, 2'd2);   // local, highest unicast: self
    send_report(16'h1234, 16'h8000, 2'd0);   // local, lowest group: none
    send_report(16'hFFFF, 16'h0001, 2'd3);   // other sender, unicast: direct
    send_report(16'hFFFF, 16'h7FFF, 2'd0);   // direct
    send_report(16'h0001, 16'hFFFF, 2'd3);   // new sender -> slot 0: changed
    send_report(16'h0001, 16'hFFFF, 2'd3);   // same status: none
    send_report(16'h0001, 16'h0000, 2'd1);   // status change: changed
    // Sender 0 aliases the lowest empty slot (slot 1, status 0).
    send_report(16'h0000, 16'h8000, 2'd0);   // same status as empty slot: none
    send_report(16'h0000, 16'h8000, 2'd2);   // writes status, slot stays empty
    // Fill slots 1..7, the cache is then full.
    for (int i = 1; i < CACHE_ENTRIES; i++) begin
      send_report(ADDR_W'(16'h8000 + i), 16'hFFFF, ST_W'(i));
    end
    send_report(16'hFFFF, 16'h0000, 2'd3);   // full miss: evicts slot 0
    send_report(16'h0000, 16'h0000, 2'd1);   // no empty slot: evicts slot 1
    send_report(16'h0000, 16'h0000, 2'd1);   // now hits the freed slot: none

    // ---- random phases ----
    // Each phase reconfigures the node address (extremes, the unicast
    // boundary, a pooled sender, a random value) on an idle block.
    for (int p = 0; p < PHASES; p++) begin
      drain_verdicts();
      pool_len = $urandom_range(4, POOL_MAX);
      for (int i = 0; i < POOL_MAX; i++) begin
        addr_pool[i] = ADDR_W'($urandom_range(1, 16'hFFFF));
      end
      // keep some pooled senders in each half of the address space
      addr_pool[0][ADDR_W-1] = 1'b1;
      addr_pool[1][ADDR_W-1] = 1'b0;
      case (p)
        0: set_node_addr(16'hFFFF);
        1: set_node_addr(16'h0000);
        2: set_node_addr(16'h7FFF);
        3: set_node_addr(16'h8000);
        4: set_node_addr(addr_pool[0]);
        default: set_node_addr(ADDR_W'($urandom));
      endcase
      // one phase runs flat out on both sides
      tx_gaps = (p != 2);
      rx_stalls = (p != 2);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        send_random_report();
        // now and then hold off until the block has fully drained
        if ($urandom_range(0, 59) == 0) drain_verdicts();
      end
    end

    drain_verdicts();
    // settle time past the longest cache walk, in case of stray beats
    repeat (30) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
